[rtl/olte_pkg.sv]
// Shared constants, types and codes of the ordered list table engine.
package olte_pkg;

	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int OUT_W    = 8;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [OUT_W-1:0]        out_t;
	typedef logic [CMP_W-1:0]        cmp_t;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_SEARCH = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_APPEND     = 3'd1,
		CELL_INSERT     = 3'd2,
		CELL_DELETE     = 3'd3,
		CELL_SCAN_START = 3'd4,
		CELL_SCAN_STEP  = 3'd5
	} cell_op_t;

	// Command broadcast from the controller to every cell of the row.
	typedef struct packed {
		cell_op_t op;
		idx_t     pos;
		cnt_t     count;
		value_t   value;
	} cell_cmd_t;

endpackage

[rtl/ordered_list_table_engine_unit.sv]
// Top level of the ordered list table engine: request control and the row of list cells.
//
// Requests arrive on the s_ stream channel, one transfer per request, and every
// request produces exactly one result transfer on the m_ channel.
// A request carries an action (append, insert, delete, search), a 1-based
// position and a signed 32-bit value. The result carries a status (done, bad
// position, list full), the 1-based position of the first match for a search
// and the number of entries held after the request.
// The list lives in a row of CAPACITY cells. Append, insert and delete are done
// in the EXEC state: every cell takes its new entry from itself, its left or right
// neighbor, or the request, all at once. A search passes a token down the row
// one cell per cycle and stops at the first match or at the end of the list.
// A request is taken in IDLE and worked on in EXEC; a search of a non-empty list
// then walks its token in SCAN. The result waits in WAIT until the output register
// is free and is then registered there.
// One request is worked on at a time; the next request is taken as soon as the
// previous result sits in the output register, even while the receiver stalls.
// A stalled receiver holds the result and its following request in place.
// Reset empties the list; entry contents are not cleared.
module ordered_list_table_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [1:0] action, [9:2] position, [41:10] value, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [1:0] status, [9:2] found_position, [17:10] entry_count
);

	localparam int CAP = olte_pkg::CAPACITY;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	olte_pkg::action_t   act_q;
	olte_pkg::pos_t      pos_q;
	olte_pkg::value_t    val_q;
	olte_pkg::cnt_t      count_q, count_d;
	olte_pkg::idx_t      scan_idx_q, scan_idx_d;
	olte_pkg::status_t   res_status_q, res_status_d;
	olte_pkg::out_t      res_found_q, res_found_d;
	logic                m_valid_q;
	logic [23:0]         m_data_q;
	olte_pkg::cell_cmd_t cmd;
	logic                load_out;

	olte_pkg::value_t    entry_w [CAP];
	logic [CAP-1:0]      token_w;
	logic [CAP-1:0]      hit_w;
	logic                hit_any;

	olte_pkg::cmp_t      pos_ext;
	olte_pkg::cmp_t      cnt_ext;
	logic                pos_nonzero;
	logic                full;

	assign s_tready    = (state_q == ST_IDLE);
	assign pos_ext     = olte_pkg::cmp_t'(pos_q);
	assign cnt_ext     = olte_pkg::cmp_t'(count_q);
	assign pos_nonzero = (pos_ext != '0);
	assign full        = (count_q == olte_pkg::cnt_t'(CAP));
	assign hit_any     = |hit_w;
	assign load_out    = (state_q == ST_WAIT) && (!m_valid_q || m_tready);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		scan_idx_d    = scan_idx_q;
		res_status_d  = res_status_q;
		res_found_d   = res_found_q;
		cmd.op        = olte_pkg::CELL_HOLD;
		cmd.pos       = olte_pkg::idx_t'(pos_ext - olte_pkg::cmp_t'(1));
		cmd.count     = count_q;
		cmd.value     = val_q;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_status_d = olte_pkg::STAT_DONE;
				res_found_d  = '0;
				state_d      = ST_WAIT;
				case (act_q)
					olte_pkg::ACT_APPEND: begin
						if (full) begin
							res_status_d = olte_pkg::STAT_FULL;
						end else begin
							cmd.op  = olte_pkg::CELL_APPEND;
							count_d = count_q + olte_pkg::cnt_t'(1);
						end
					end
					olte_pkg::ACT_INSERT: begin
						if (!pos_nonzero || pos_ext > cnt_ext + olte_pkg::cmp_t'(1)) begin
							res_status_d = olte_pkg::STAT_BADPOS;
						end else if (full) begin
							res_status_d = olte_pkg::STAT_FULL;
						end else begin
							cmd.op  = olte_pkg::CELL_INSERT;
							count_d = count_q + olte_pkg::cnt_t'(1);
						end
					end
					olte_pkg::ACT_DELETE: begin
						if (!pos_nonzero || pos_ext > cnt_ext) begin
							res_status_d = olte_pkg::STAT_BADPOS;
						end else begin
							cmd.op  = olte_pkg::CELL_DELETE;
							count_d = count_q - olte_pkg::cnt_t'(1);
						end
					end
					default: begin
						if (count_q != '0) begin
							cmd.op     = olte_pkg::CELL_SCAN_START;
							scan_idx_d = '0;
							state_d    = ST_SCAN;
						end
					end
				endcase
			end
			ST_SCAN: begin
				if (hit_any) begin
					res_found_d = olte_pkg::out_t'(olte_pkg::cnt_t'(scan_idx_q)
						+ olte_pkg::cnt_t'(1));
					state_d     = ST_WAIT;
				end else if (olte_pkg::cnt_t'(scan_idx_q) + olte_pkg::cnt_t'(1) >= count_q) begin
					res_found_d = '0;
					state_d     = ST_WAIT;
				end else begin
					cmd.op     = olte_pkg::CELL_SCAN_STEP;
					scan_idx_d = scan_idx_q + olte_pkg::idx_t'(1);
				end
			end
			ST_WAIT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			scan_idx_q <= scan_idx_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q <= olte_pkg::action_t'(s_tdata[1:0]);
			pos_q <= s_tdata[9:2];
			val_q <= s_tdata[41:10];
		end
		res_status_q <= res_status_d;
		res_found_q  <= res_found_d;
		if (load_out) begin
			m_data_q <= {6'b0, olte_pkg::out_t'(count_q), res_found_q, res_status_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		olte_pkg::value_t left_entry;
		olte_pkg::value_t right_entry;
		logic             left_token;

		if (i == 0) begin : g_first
			assign left_entry = '0;
			assign left_token = 1'b0;
		end else begin : g_mid_left
			assign left_entry = entry_w[i-1];
			assign left_token = token_w[i-1];
		end

		if (i == CAP - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_mid_right
			assign right_entry = entry_w[i+1];
		end

		olte_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.idx         (olte_pkg::idx_t'(i)),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.left_token  (left_token),
			.entry       (entry_w[i]),
			.token       (token_w[i]),
			.hit         (hit_w[i])
		);
	end

endmodule

[rtl/olte_cell.sv]
// One list cell: holds one entry, shifts with its neighbors and passes the search token.
module olte_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  olte_pkg::cell_cmd_t cmd,
	input  olte_pkg::idx_t      idx,
	input  olte_pkg::value_t    left_entry,
	input  olte_pkg::value_t    right_entry,
	input  logic                left_token,
	output olte_pkg::value_t    entry,
	output logic                token,
	output logic                hit
);

	olte_pkg::value_t entry_q;
	olte_pkg::value_t entry_d;
	logic             token_q;
	olte_pkg::cnt_t   idx_ext;

	assign idx_ext = olte_pkg::cnt_t'(idx);

	always_comb begin
		entry_d = entry_q;
		unique case (cmd.op)
			olte_pkg::CELL_APPEND: begin
				if (idx_ext == cmd.count) begin
					entry_d = cmd.value;
				end
			end
			olte_pkg::CELL_INSERT: begin
				if (idx == cmd.pos) begin
					entry_d = cmd.value;
				end else if (idx > cmd.pos && idx_ext <= cmd.count) begin
					entry_d = left_entry;
				end
			end
			olte_pkg::CELL_DELETE: begin
				if (idx >= cmd.pos && (idx_ext + olte_pkg::cnt_t'(1)) < cmd.count) begin
					entry_d = right_entry;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else begin
			case (cmd.op)
				olte_pkg::CELL_SCAN_START: token_q <= (idx == '0);
				olte_pkg::CELL_SCAN_STEP:  token_q <= left_token;
				default:                   token_q <= token_q;
			endcase
		end
	end

	assign entry = entry_q;
	assign token = token_q;
	// Only the cell holding the token reports, and only inside the live list.
	assign hit   = token_q && (entry_q == cmd.value) && (idx_ext < cmd.count);

endmodule
